@@ sv/mlnp_pkg.sv @@
// Shared types and constants for the monophonic last-note-priority slot unit.
// Holds the sequencer state type, slot status codes and the sequencer control bundle.
// No dependencies.
`default_nettype none

package mlnp_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int AGE_BITS_DEF   = 48;

    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int FRAME_W = 16;
    localparam int SLOT_W  = 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPD,
        S_READ,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        ST_INVALID = 2'd0,
        ST_ON      = 2'd1,
        ST_WAIT    = 2'd2
    } t_slot_st;

    typedef struct packed {
        logic idle;     // ready for a new item
        logic start;    // item accepted this cycle
        logic rd_scan;  // issue a table read at the scan address
        logic beat;     // read data of one slot is present
        logic upd;      // commit the event to the table
        logic rd_cur;   // read the sounding slot for the result
        logic out_vld;  // result item is presented
    } t_seq_ctl;

endpackage

`default_nettype wire

@@ sv/mono_last_note_priority_slots_unit.sv @@
// Top level of the monophonic last-note-priority voice allocator.
// Holds slot status, search accumulators with the shared age comparator, the age counter
// and the result stage. Uses mlnp_pkg, mlnp_seq and mlnp_slot_ram.
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_stall    i_note_number, i_note_velocity,
//                                                  i_frame_offset
//   out      output     o_out_valid / i_out_stall  o_voice_changed, o_voice_valid,
//                                                  o_voice_slot, o_voice_note,
//                                                  o_voice_velocity, o_voice_frame
//
// An accepted item passes through the scan, commit, read and result states in that order.
// The result is held until it is taken; the unit then returns to idle and only there accepts
// the next item, so a new item is not taken while one is in flight. The scan reads every slot
// through the single table read port (read data is registered), then the event is committed,
// the sounding slot is read back and the result is offered. o_in_stall is high from acceptance
// until the result is taken.
// Reset clears all slot status, the age counter and the sounding voice.
`default_nettype none

module mono_last_note_priority_slots_unit
    import mlnp_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int AGE_BITS   = AGE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [NOTE_W-1:0]  i_note_number,
    input  wire logic [VEL_W-1:0]   i_note_velocity,
    input  wire logic [FRAME_W-1:0] i_frame_offset,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_voice_changed,
    output logic                    o_voice_valid,
    output logic      [SLOT_W-1:0]  o_voice_slot,
    output logic      [NOTE_W-1:0]  o_voice_note,
    output logic      [VEL_W-1:0]   o_voice_velocity,
    output logic      [FRAME_W-1:0] o_voice_frame
);

    localparam int IW      = $clog2(SLOT_COUNT);
    localparam int DATA_W  = NOTE_W + VEL_W + FRAME_W + AGE_BITS;
    localparam int FRM_LO  = AGE_BITS;
    localparam int VEL_LO  = FRM_LO + FRAME_W;
    localparam int NOTE_LO = VEL_LO + VEL_W;

    t_seq_ctl           ctl;
    logic [IW-1:0]      scan_addr;
    logic [IW-1:0]      beat_idx;

    logic [NOTE_W-1:0]  r_in_note;
    logic [VEL_W-1:0]   r_in_vel;
    logic [FRAME_W-1:0] r_in_frame;
    logic               note_on;

    t_slot_st           r_st [SLOT_COUNT];
    logic [AGE_BITS-1:0] r_age_cnt;
    logic [AGE_BITS-1:0] n_age;
    logic               r_cur_valid;
    logic [IW-1:0]      r_cur_slot;
    logic               r_changed;

    logic               r_hit_any;
    logic               r_free_f;
    logic [IW-1:0]      r_free_idx;
    logic               r_min_f;
    logic [IW-1:0]      r_min_idx;
    logic [AGE_BITS-1:0] r_min_age;
    logic               r_on_f;
    logic [IW-1:0]      r_on_idx;
    logic               r_wait_f;
    logic [IW-1:0]      r_wait_idx;
    logic               r_res_f;
    logic [IW-1:0]      r_res_idx;
    logic [AGE_BITS-1:0] r_res_age;

    logic [DATA_W-1:0]  rd_data;
    logic [AGE_BITS-1:0] b_age;
    logic [NOTE_W-1:0]  b_note;
    t_slot_st           b_st;
    logic               b_valid;
    logic               b_match;
    logic [AGE_BITS-1:0] cmp_a;
    logic [AGE_BITS-1:0] cmp_b;
    logic               age_lt;

    logic               wr_en;
    logic [IW-1:0]      pick;
    logic [DATA_W-1:0]  wr_data;
    logic               rd_en;
    logic [IW-1:0]      rd_addr;

    mlnp_seq #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_ctl       (ctl),
        .o_scan_addr (scan_addr),
        .o_beat_idx  (beat_idx)
    );

    assign rd_en   = ctl.rd_scan | ctl.rd_cur;
    assign rd_addr = ctl.rd_scan ? scan_addr : r_cur_slot;

    mlnp_slot_ram #(
        .SLOT_COUNT (SLOT_COUNT),
        .DATA_W     (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (pick),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign o_in_stall = !ctl.idle;
    assign note_on    = (r_in_vel != '0);

    always_ff @(posedge i_clk) begin
        if (ctl.start) begin
            r_in_note  <= i_note_number;
            r_in_vel   <= i_note_velocity;
            r_in_frame <= i_frame_offset;
        end
    end

    // per-slot view of the current scan beat
    assign b_age   = rd_data[AGE_BITS-1:0];
    assign b_note  = rd_data[NOTE_LO +: NOTE_W];
    assign b_st    = r_st[beat_idx];
    assign b_valid = (b_st != ST_INVALID);
    assign b_match = (b_note == r_in_note);

    // shared age comparator: oldest slot for note-on, newest slot for resume
    always_comb begin
        if (note_on) begin
            cmp_a = b_age;
            cmp_b = r_min_age;
        end else begin
            cmp_a = r_res_age;
            cmp_b = b_age;
        end
    end
    assign age_lt = (cmp_a < cmp_b);

    always_ff @(posedge i_clk) begin
        if (ctl.start) begin
            r_hit_any <= 1'b0;
            r_free_f  <= 1'b0;
            r_min_f   <= 1'b0;
            r_on_f    <= 1'b0;
            r_wait_f  <= 1'b0;
            r_res_f   <= 1'b0;
        end else if (ctl.beat) begin
            if (note_on) begin
                if (b_valid && b_match) r_hit_any <= 1'b1;
                if (!b_valid && !r_free_f) begin
                    r_free_f   <= 1'b1;
                    r_free_idx <= beat_idx;
                end
                if (!r_min_f || age_lt) begin
                    r_min_f   <= 1'b1;
                    r_min_idx <= beat_idx;
                    r_min_age <= b_age;
                end
            end else begin
                if (b_st == ST_ON && b_match && !r_on_f) begin
                    r_on_f   <= 1'b1;
                    r_on_idx <= beat_idx;
                end
                if (b_st == ST_WAIT && b_match && !r_wait_f) begin
                    r_wait_f   <= 1'b1;
                    r_wait_idx <= beat_idx;
                end
                // skip the slot that this note-off releases
                if (b_valid && !(b_st == ST_ON && b_match) && (!r_res_f || age_lt)) begin
                    r_res_f   <= 1'b1;
                    r_res_idx <= beat_idx;
                    r_res_age <= b_age;
                end
            end
        end
    end

    assign n_age   = (r_age_cnt == '1) ? r_age_cnt : r_age_cnt + AGE_BITS'(1);
    assign pick    = r_free_f ? r_free_idx : r_min_idx;
    assign wr_en   = ctl.upd && note_on && !r_hit_any;
    assign wr_data = {r_in_note, r_in_vel, r_in_frame, n_age};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_st[i] <= ST_INVALID;
            end
            r_age_cnt   <= '0;
            r_cur_valid <= 1'b0;
            r_cur_slot  <= '0;
            r_changed   <= 1'b0;
        end else if (ctl.upd) begin
            r_changed <= 1'b0;
            if (note_on) begin
                if (!r_hit_any) begin
                    // park the sounding note, then sound the new one
                    if (r_cur_valid) r_st[r_cur_slot] <= ST_WAIT;
                    r_st[pick]  <= ST_ON;
                    r_age_cnt   <= n_age;
                    r_cur_valid <= 1'b1;
                    r_cur_slot  <= pick;
                    r_changed   <= 1'b1;
                end
            end else if (r_on_f) begin
                r_st[r_on_idx] <= ST_INVALID;
                if (r_res_f) begin
                    r_st[r_res_idx] <= ST_ON;
                    r_cur_valid     <= 1'b1;
                    r_cur_slot      <= r_res_idx;
                end else begin
                    r_cur_valid <= 1'b0;
                    r_cur_slot  <= '0;
                end
                r_changed <= 1'b1;
            end else if (r_wait_f) begin
                r_st[r_wait_idx] <= ST_INVALID;
            end
        end
    end

    assign o_out_valid      = ctl.out_vld;
    assign o_voice_changed  = r_changed;
    assign o_voice_valid    = r_cur_valid;
    assign o_voice_slot     = r_cur_valid ? SLOT_W'(r_cur_slot) : '0;
    assign o_voice_note     = r_cur_valid ? rd_data[NOTE_LO +: NOTE_W] : '0;
    assign o_voice_velocity = r_cur_valid ? rd_data[VEL_LO +: VEL_W] : '0;
    assign o_voice_frame    = r_cur_valid ? rd_data[FRM_LO +: FRAME_W] : '0;

endmodule

`default_nettype wire

@@ sv/mlnp_slot_ram.sv @@
// Slot table storage: note, velocity, frame and age stamp of each slot.
// One write port, one read port with registered read data. Uses mlnp_pkg.
`default_nettype none

module mlnp_slot_ram
    import mlnp_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int DATA_W     = NOTE_W + VEL_W + FRAME_W + AGE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [$clog2(SLOT_COUNT)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]             i_wdata,
    input  wire logic                          i_re,
    input  wire logic [$clog2(SLOT_COUNT)-1:0] i_raddr,
    output logic      [DATA_W-1:0]             o_rdata
);

    logic [DATA_W-1:0] r_mem [SLOT_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/mlnp_seq.sv @@
// Sequencer for one note event: accept, slot scan, commit, result read, hand-off.
// Owns the scan counter and drives the control bundle. Uses mlnp_pkg.
`default_nettype none

module mlnp_seq
    import mlnp_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_out_stall,
    output t_seq_ctl                           o_ctl,
    output logic      [$clog2(SLOT_COUNT)-1:0] o_scan_addr,
    output logic      [$clog2(SLOT_COUNT)-1:0] o_beat_idx
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [CW-1:0] CNT_LAST = CW'(SLOT_COUNT);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] beat_cnt;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_SCAN;
            S_SCAN: if (r_cnt == CNT_LAST) n_state = S_UPD;
            S_UPD:  n_state = S_READ;
            S_READ: n_state = S_OUT;
            S_OUT:  if (!i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (r_state == S_IDLE) begin
            n_cnt = '0;
        end else if (r_state == S_SCAN && r_cnt != CNT_LAST) begin
            n_cnt = r_cnt + CW'(1);
        end
    end

    always_comb begin
        o_ctl = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ctl.idle  = 1'b1;
                o_ctl.start = i_in_valid;
            end
            S_SCAN: begin
                o_ctl.rd_scan = (r_cnt != CNT_LAST);
                o_ctl.beat    = (r_cnt != '0);
            end
            S_UPD:  o_ctl.upd     = 1'b1;
            S_READ: o_ctl.rd_cur  = 1'b1;
            S_OUT:  o_ctl.out_vld = 1'b1;
            default: o_ctl = '0;
        endcase
    end

    // read data is registered, so the beat index trails the scan address by one
    assign beat_cnt    = r_cnt - CW'(1);
    assign o_scan_addr = r_cnt[IW-1:0];
    assign o_beat_idx  = beat_cnt[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for mono_last_note_priority_slots_unit.
// Drives note events, predicts each voice result with a slot-table model, checks every result.
// Depends on mlnp_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb
    import mlnp_pkg::*;
();

    localparam int IDLE_LIMIT = 3000;
    localparam int POOL_SPAN  = 20;

    typedef struct {
        logic               changed;
        logic               valid;
        logic [SLOT_W-1:0]  slot;
        logic [NOTE_W-1:0]  note;
        logic [VEL_W-1:0]   vel;
        logic [FRAME_W-1:0] frame;
    } t_voice;

    typedef enum {
        EV_ON_POOL,
        EV_OFF_SOUNDING,
        EV_OFF_HELD,
        EV_OFF_NOISE,
        EV_ON_WIDE
    } t_ev_kind;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_in_valid      = 1'b0;
    logic [NOTE_W-1:0]  i_note_number   = '0;
    logic [VEL_W-1:0]   i_note_velocity = '0;
    logic [FRAME_W-1:0] i_frame_offset  = '0;
    logic               i_out_stall     = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic               o_voice_changed;
    logic               o_voice_valid;
    logic [SLOT_W-1:0]  o_voice_slot;
    logic [NOTE_W-1:0]  o_voice_note;
    logic [VEL_W-1:0]   o_voice_velocity;
    logic [FRAME_W-1:0] o_voice_frame;

    // slot table model
    t_slot_st                slot_st    [SLOT_COUNT_DEF];
    logic [NOTE_W-1:0]       slot_note  [SLOT_COUNT_DEF];
    logic [VEL_W-1:0]        slot_vel   [SLOT_COUNT_DEF];
    logic [FRAME_W-1:0]      slot_frame [SLOT_COUNT_DEF];
    logic [AGE_BITS_DEF-1:0] slot_age   [SLOT_COUNT_DEF];
    logic [AGE_BITS_DEF-1:0] age_ctr;
    logic                    cur_valid;
    int                      cur_slot;

    t_voice voice_q[$];
    t_voice want;
    int     n_errors   = 0;
    int     n_events   = 0;
    int     n_changes  = 0;
    int     n_takeover = 0;
    int     idle_cycles = 0;
    bit     no_idle    = 1'b0;

    mono_last_note_priority_slots_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_note_number    (i_note_number),
        .i_note_velocity  (i_note_velocity),
        .i_frame_offset   (i_frame_offset),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_voice_changed  (o_voice_changed),
        .o_voice_valid    (o_voice_valid),
        .o_voice_slot     (o_voice_slot),
        .o_voice_note     (o_voice_note),
        .o_voice_velocity (o_voice_velocity),
        .o_voice_frame    (o_voice_frame)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic clear_slots();
        for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
            slot_st[i]    = ST_INVALID;
            slot_note[i]  = '0;
            slot_vel[i]   = '0;
            slot_frame[i] = '0;
            slot_age[i]   = '0;
        end
        age_ctr   = '0;
        cur_valid = 1'b0;
        cur_slot  = 0;
    endtask

    // Apply one accepted event to the slot table and queue the voice it leaves.
    task automatic predict_voice(input logic [NOTE_W-1:0] note, input logic [VEL_W-1:0] vel,
                                 input logic [FRAME_W-1:0] frame);
        t_voice r;
        int     pick;
        int     hit;
        bit     held;
        r.changed = 1'b0;
        if (vel != 0) begin
            held = 1'b0;
            for (int i = 0; i < SLOT_COUNT_DEF; i++)
                if (slot_st[i] != ST_INVALID && slot_note[i] == note) held = 1'b1;
            if (!held) begin
                if (cur_valid) slot_st[cur_slot] = ST_WAIT;
                pick = -1;
                for (int i = 0; i < SLOT_COUNT_DEF; i++)
                    if (pick < 0 && slot_st[i] == ST_INVALID) pick = i;
                if (pick < 0) begin
                    // table full: take the oldest slot, lowest index on a tie
                    pick = 0;
                    for (int i = 1; i < SLOT_COUNT_DEF; i++)
                        if (slot_age[i] < slot_age[pick]) pick = i;
                    n_takeover++;
                end
                if (age_ctr != '1) age_ctr++;
                slot_note[pick]  = note;
                slot_vel[pick]   = vel;
                slot_frame[pick] = frame;
                slot_age[pick]   = age_ctr;
                slot_st[pick]    = ST_ON;
                cur_valid = 1'b1;
                cur_slot  = pick;
                r.changed = 1'b1;
            end
        end else begin
            hit = -1;
            for (int i = 0; i < SLOT_COUNT_DEF; i++)
                if (hit < 0 && slot_st[i] == ST_ON && slot_note[i] == note) hit = i;
            if (hit >= 0) begin
                // resume the newest remaining slot
                slot_st[hit] = ST_INVALID;
                pick = -1;
                for (int i = 0; i < SLOT_COUNT_DEF; i++)
                    if (slot_st[i] != ST_INVALID && (pick < 0 || slot_age[pick] < slot_age[i]))
                        pick = i;
                if (pick >= 0) begin
                    slot_st[pick] = ST_ON;
                    cur_valid = 1'b1;
                    cur_slot  = pick;
                end else begin
                    cur_valid = 1'b0;
                    cur_slot  = 0;
                end
                r.changed = 1'b1;
            end else begin
                for (int i = 0; i < SLOT_COUNT_DEF; i++)
                    if (hit < 0 && slot_st[i] == ST_WAIT && slot_note[i] == note) hit = i;
                if (hit >= 0) slot_st[hit] = ST_INVALID;
            end
        end
        r.valid = cur_valid;
        r.slot  = cur_valid ? cur_slot[SLOT_W-1:0] : '0;
        r.note  = cur_valid ? slot_note[cur_slot]  : '0;
        r.vel   = cur_valid ? slot_vel[cur_slot]   : '0;
        r.frame = cur_valid ? slot_frame[cur_slot] : '0;
        n_events++;
        if (r.changed) n_changes++;
        voice_q.push_back(r);
    endtask

    // Present one item; keep valid high after acceptance so a back-to-back item needs no toggle.
    task automatic send_note(input logic [NOTE_W-1:0] note, input logic [VEL_W-1:0] vel,
                             input logic [FRAME_W-1:0] frame);
        int gap = 0;
        if (!no_idle)
            while ($urandom_range(99) < 11) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_note_number   <= note;
        i_note_velocity <= vel;
        i_frame_offset  <= frame;
        do @(posedge i_clk); while (o_in_stall);
        predict_voice(note, vel, frame);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (voice_q.size() != 0);
    endtask

    function automatic logic [NOTE_W-1:0] held_note();
        int picks[$];
        for (int i = 0; i < SLOT_COUNT_DEF; i++)
            if (slot_st[i] != ST_INVALID) picks.push_back(i);
        if (picks.size() == 0) return NOTE_W'($urandom_range(127));
        return slot_note[picks[$urandom_range(picks.size() - 1)]];
    endfunction

    // Single voice: extremes of the fields, ignored events, waiting and sounding note-offs.
    task automatic test_single_voice();
        send_note(7'd0,   7'd127, 16'hFFFF);
        send_note(7'd127, 7'd1,   16'h0000);
        send_note(7'd127, 7'd64,  16'h1234);  // already sounding: ignored
        send_note(7'd0,   7'd5,   16'h5555);  // already waiting: ignored
        send_note(7'd55,  7'd0,   16'hAAAA);  // held nowhere
        send_note(7'd0,   7'd0,   16'h0F0F);  // free the waiting note
        send_note(7'd127, 7'd0,   16'hF0F0);  // last note off: nothing sounds
        send_note(7'd127, 7'd0,   16'h0001);
        wait_idle();
    endtask

    // Fill every slot, overflow into the oldest ones, then resume after a note-off.
    task automatic test_full_table();
        for (int i = 0; i < SLOT_COUNT_DEF + 2; i++)
            send_note(NOTE_W'(10 + 3 * i), VEL_W'($urandom_range(1, 127)),
                      FRAME_W'($urandom));
        send_note(NOTE_W'(10 + 3 * (SLOT_COUNT_DEF + 1)), 7'd0, FRAME_W'($urandom));
        wait_idle();
    endtask

    // Mostly play within a narrow pool of notes so the table fills and notes overlap.
    task automatic test_random_play(input int count);
        t_ev_kind          kind;
        int                roll;
        int                base;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
        base = 0;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) base = $urandom_range(127 - POOL_SPAN + 1);
            no_idle = (n >= count / 3) && (n < count / 2);
            roll = $urandom_range(99);
            if (roll < 50)      kind = EV_ON_POOL;
            else if (roll < 75) kind = EV_OFF_SOUNDING;
            else if (roll < 88) kind = EV_OFF_HELD;
            else if (roll < 95) kind = EV_OFF_NOISE;
            else                kind = EV_ON_WIDE;
            vel = VEL_W'($urandom_range(1, 127));
            case (kind)
                EV_ON_POOL:      note = NOTE_W'(base + $urandom_range(POOL_SPAN - 1));
                EV_OFF_SOUNDING: note = cur_valid ? slot_note[cur_slot] : held_note();
                EV_OFF_HELD:     note = held_note();
                default:         note = NOTE_W'($urandom_range(127));
            endcase
            if (kind != EV_ON_POOL && kind != EV_ON_WIDE) vel = '0;
            send_note(note, vel, FRAME_W'($urandom));
        end
        no_idle = 1'b0;
        wait_idle();
    endtask

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= !no_idle && ($urandom_range(99) < 11);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (voice_q.size() == 0) begin
                n_errors++;
                $display("%0t: result with no event pending", $time);
            end else begin
                want = voice_q.pop_front();
                check_field("voice_changed",  16'(want.changed), 16'(o_voice_changed));
                check_field("voice_valid",    16'(want.valid),   16'(o_voice_valid));
                check_field("voice_slot",     16'(want.slot),    16'(o_voice_slot));
                check_field("voice_note",     16'(want.note),    16'(o_voice_note));
                check_field("voice_velocity", 16'(want.vel),     16'(o_voice_velocity));
                check_field("voice_frame",    want.frame,        o_voice_frame);
            end
        end
    end

    // watchdog: count cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        clear_slots();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_voice();
        test_full_table();
        test_random_play(1000);
        repeat (40) @(posedge i_clk);
        $display("covered %0d note events: %0d voice changes, %0d takeovers of the oldest slot",
                 n_events, n_changes, n_takeover);
        $display("%0d mismatches", n_errors);
        if (n_errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
